[rtl/core/min_line_cover_points_unit_defines.svh]
// Assertion macros shared by the checker.
`ifndef MIN_LINE_COVER_POINTS_UNIT_DEFINES_SVH
`define MIN_LINE_COVER_POINTS_UNIT_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define MLC_ASSERT_IMP(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define MLC_ASSERT_NXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`endif

[rtl/core/mlc_pkg.sv]
// ----------------------------------------------------------------------------
// mlc_pkg
// Shared types and constants of the minimum line cover unit.
// ----------------------------------------------------------------------------
package mlc_pkg;
  localparam int LineCap = 8;
  localparam int ResBits = 4;
  typedef logic [ResBits-1:0] res_t;
  // Control from the sequencer to the datapath.
  typedef struct packed {
    logic clr;
    logic load;
  } ctl_t;
endpackage

[rtl/core/mlc_dp.sv]
// ----------------------------------------------------------------------------
// mlc_dp
// Shared multiplier pair for the cross-product collinearity test.
// ----------------------------------------------------------------------------
module mlc_dp import mlc_pkg::*; #(
  parameter int COORD_BITS = 11
) (
  input  logic                    clk,
  input  logic signed [COORD_BITS:0] da1,
  input  logic signed [COORD_BITS:0] db1,
  input  logic signed [COORD_BITS:0] da2,
  input  logic signed [COORD_BITS:0] db2,
  output logic                    eq_r
);
  localparam int PW = 2*COORD_BITS+2;
  logic signed [PW-1:0] p1_r, p2_r;

  // One product per side, registered, then compared.
  always_ff @(posedge clk) begin
    p1_r <= da1 * db1;
    p2_r <= da2 * db2;
    eq_r <= (p1_r == p2_r);
  end
endmodule

[rtl/core/min_line_cover_points_unit.sv]
// ----------------------------------------------------------------------------
// min_line_cover_points_unit
// Loads points, builds pair line masks, then walks the subset table.
// ----------------------------------------------------------------------------
// channel   dir  signals
// input     in   start, in_x_coord, in_y_coord, in_last_point (busy is out)
// result    out  out_valid, out_min_lines
// Points load one per cycle while the unit is not busy. The final point starts
// a solve: the mask build steps each (pair, point) through S_MUL, S_MW1, S_MW2
// and S_MNEXT on the shared multiplier pair, and the table walk steps each
// (subset, candidate) through S_RD, S_RW and S_CMP on the table memory read
// port, with extra steps per skipped point and per subset. busy is high meanwhile.
// Reset is synchronous and empties the point store. The result strobe lasts
// one cycle; the receiver cannot stall it.
module min_line_cover_points_unit import mlc_pkg::*; #(
  parameter int MAX_POINTS = 16,
  parameter int COORD_BITS = 11
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [COORD_BITS-1:0] in_x_coord,
  input  logic signed [COORD_BITS-1:0] in_y_coord,
  input  logic                         in_last_point,
  output logic                         out_valid,
  output logic [3:0]                   out_min_lines
);
  localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS+1);
  localparam int TD = 1 << MAX_POINTS;
  localparam int MW = MAX_POINTS + 1;

  localparam logic [3:0] S_IDLE = 4'd0, S_PAIR = 4'd1, S_MUL = 4'd2,
    S_MW1 = 4'd3, S_MW2 = 4'd4, S_MNEXT = 4'd5, S_SUB = 4'd6, S_CAND = 4'd7,
    S_RD = 4'd8, S_RW = 4'd9, S_CMP = 4'd10, S_WR = 4'd11, S_DONE = 4'd12;

  logic [3:0] st_r;
  logic signed [COORD_BITS-1:0] px_r [MAX_POINTS];
  logic signed [COORD_BITS-1:0] py_r [MAX_POINTS];
  logic [CW-1:0] cnt_r;
  logic [IW-1:0] i_r, j_r, k_r;
  logic [MAX_POINTS-1:0] lm_r;
  logic [MAX_POINTS-1:0] lmem [MAX_POINTS*MAX_POINTS];
  logic [MAX_POINTS-1:0] lrd_r;
  res_t tmem [TD];
  res_t trd_r, best_r;
  logic [MW-1:0] m_r;
  logic [MAX_POINTS-1:0] full;
  logic same, eq_r;
  ctl_t ctl;
  logic signed [COORD_BITS:0] da1, db1, da2, db2;
  logic [2*IW-1:0] lidx_w, lidx_r;
  logic [MAX_POINTS-1:0] msk;
  logic [CW-1:0] pc;
  logic [IW-1:0] first_free;

  assign busy = (st_r != S_IDLE);
  assign ctl.load = start && !busy && (cnt_r < CW'(MAX_POINTS));
  assign ctl.clr  = (st_r == S_DONE);
  assign full = MAX_POINTS'((MW'(1) << cnt_r) - MW'(1));
  assign msk = m_r[MAX_POINTS-1:0];
  assign same = (px_r[i_r] == px_r[j_r]) && (py_r[i_r] == py_r[j_r]);
  assign da1 = (COORD_BITS+1)'(py_r[i_r]) - (COORD_BITS+1)'(py_r[j_r]);
  assign db1 = (COORD_BITS+1)'(px_r[j_r]) - (COORD_BITS+1)'(px_r[k_r]);
  assign da2 = (COORD_BITS+1)'(px_r[i_r]) - (COORD_BITS+1)'(px_r[j_r]);
  assign db2 = (COORD_BITS+1)'(py_r[j_r]) - (COORD_BITS+1)'(py_r[k_r]);
  assign lidx_w = {i_r, j_r};

  // Popcount of the subset, narrow loop over independent bits.
  always_comb begin
    pc = '0;
    for (int b = 0; b < MAX_POINTS; b++) pc = pc + CW'(msk[b]);
  end

  // First uncovered point, narrow priority pick.
  always_comb begin
    first_free = '0;
    for (int b = MAX_POINTS-1; b >= 0; b--)
      if (!msk[b]) first_free = IW'(b);
  end

  mlc_dp #(.COORD_BITS(COORD_BITS)) u_dp (
    .clk(clk), .da1(da1), .db1(db1), .da2(da2), .db2(db2), .eq_r(eq_r));

  // Point store.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      px_r[cnt_r[IW-1:0]] <= in_x_coord;
      py_r[cnt_r[IW-1:0]] <= in_y_coord;
    end
  end

  // Line mask memory and subset table memory, each with one write and one read port.
  always_ff @(posedge clk) begin
    lidx_r <= lidx_w;
    if (st_r == S_MNEXT && k_r == IW'(cnt_r - 1'b1))
      lmem[lidx_w] <= lm_r | ((!same && eq_r) ? (MAX_POINTS'(1) << k_r) : '0);
    lrd_r <= lmem[lidx_w];
    if (st_r == S_WR) tmem[msk] <= best_r;
    trd_r <= tmem[(msk | lrd_r) & full];
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    out_valid <= rst_n && (st_r == S_DONE);
    if (!rst_n) begin
      st_r <= S_IDLE;
      cnt_r <= '0;
    end else begin
      case (st_r)
        S_IDLE: begin
          if (start) begin
            if (ctl.load) cnt_r <= cnt_r + 1'b1;
            if (in_last_point) begin
              i_r <= '0; j_r <= IW'(1); k_r <= '0;
              lm_r <= '0;
              if (ctl.load && cnt_r + 1'b1 >= CW'(2)) st_r <= S_PAIR;
              else if (!ctl.load && cnt_r >= CW'(2)) st_r <= S_PAIR;
              else st_r <= S_DONE;
              best_r <= (ctl.load || cnt_r != '0) ? res_t'(1) : res_t'(0);
            end
          end
        end
        S_PAIR: begin
          lm_r <= (MAX_POINTS'(1) << i_r) | (MAX_POINTS'(1) << j_r);
          k_r <= '0;
          st_r <= S_MUL;
        end
        S_MUL: st_r <= S_MW1;
        S_MW1: st_r <= S_MW2;
        S_MW2: begin
          if (same ? (px_r[k_r] == px_r[i_r] && py_r[k_r] == py_r[i_r]) : eq_r)
            lm_r <= lm_r | (MAX_POINTS'(1) << k_r);
          st_r <= S_MNEXT;
        end
        S_MNEXT: begin
          if (k_r != IW'(cnt_r - 1'b1)) begin
            k_r <= k_r + 1'b1;
            st_r <= S_MUL;
          end else if (j_r != IW'(cnt_r - 1'b1)) begin
            j_r <= j_r + 1'b1;
            st_r <= S_PAIR;
          end else if (i_r != IW'(cnt_r - 2'd2)) begin
            i_r <= i_r + 1'b1;
            j_r <= i_r + 2'd2;
            st_r <= S_PAIR;
          end else begin
            m_r <= MW'(full);
            st_r <= S_SUB;
          end
        end
        S_SUB: begin
          if (msk == full) begin
            best_r <= '0; st_r <= S_WR;
          end else if (pc + 1'b1 == cnt_r || pc + 2'd2 == cnt_r) begin
            best_r <= res_t'(1); st_r <= S_WR;
          end else begin
            best_r <= res_t'(LineCap);
            i_r <= first_free;
            st_r <= S_CAND;
          end
        end
        S_CAND: begin
          j_r <= i_r + 1'b1;
          st_r <= S_RD;
        end
        S_RD: begin
          if (CW'(j_r) >= cnt_r || j_r == '0) st_r <= S_WR;
          else if (msk[j_r]) j_r <= j_r + 1'b1;
          else st_r <= S_RW;
        end
        S_RW: st_r <= S_CMP;
        S_CMP: begin
          if (trd_r + 1'b1 < best_r && lidx_r == lidx_w) best_r <= trd_r + 1'b1;
          if (j_r == IW'(MAX_POINTS-1)) st_r <= S_WR;
          else begin
            j_r <= j_r + 1'b1; st_r <= S_RD;
          end
        end
        S_WR: begin
          if (msk == '0) st_r <= S_DONE;
          else begin
            m_r <= m_r - 1'b1; st_r <= S_SUB;
          end
        end
        S_DONE: begin
          out_min_lines <= best_r;
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
      if (ctl.clr) cnt_r <= '0;
    end
  end
endmodule

[rtl/core/mlc_checker.sv]
// ----------------------------------------------------------------------------
// mlc_checker
// Port-level checks of the minimum line cover unit.
// ----------------------------------------------------------------------------
`include "min_line_cover_points_unit_defines.svh"
module mlc_checker import mlc_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       in_last_point,
  input logic       out_valid,
  input logic [3:0] out_min_lines
);
  // A result never exceeds the line cap.
  `MLC_ASSERT_IMP(a_cap, clk, rst_n, out_valid, out_min_lines <= 4'(LineCap))
  // The unit is idle while a result beat is shown.
  `MLC_ASSERT_IMP(a_idle, clk, rst_n, out_valid, !busy)
  // A non-final point does not make the unit busy.
  `MLC_ASSERT_NXT(a_load, clk, rst_n, start && !busy && !in_last_point, !busy)
  // The strobe lasts one cycle.
  `MLC_ASSERT_NXT(a_pulse, clk, rst_n, out_valid, !out_valid)
endmodule

bind min_line_cover_points_unit mlc_checker u_mlc_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .in_last_point(in_last_point), .out_valid(out_valid),
  .out_min_lines(out_min_lines));

[tb/sv/testbench.sv]
// ----------------------------------------------------------------------------
// Minimum line cover unit testbench
// Streams point sets into the unit and checks each reported line count
// against a local subset-table predictor. Small sets run first, then
// coincident points, the eight-line cap with a dropped extra point, and
// finally random sets under three sender idle patterns.
// ----------------------------------------------------------------------------
module testbench;
  import mlc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumSlots = 16;
  localparam int CoordW = 11;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic signed [CoordW-1:0] in_x_coord;
  logic signed [CoordW-1:0] in_y_coord;
  logic in_last_point;
  logic out_valid;
  logic [3:0] out_min_lines;

  min_line_cover_points_unit #(
    .MAX_POINTS(NumSlots),
    .COORD_BITS(CoordW)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_x_coord(in_x_coord),
    .in_y_coord(in_y_coord),
    .in_last_point(in_last_point),
    .out_valid(out_valid),
    .out_min_lines(out_min_lines)
  );

  // Predictor state: stored points, pair masks and the subset table.
  longint pt_x[NumSlots];
  longint pt_y[NumSlots];
  int stored_pts;
  logic [15:0] pair_mask[NumSlots][NumSlots];
  logic [3:0] fewest_left[65536];

  res_t expected_lines[$];
  int send_idle_pct;
  int points_sent;
  int mismatches;
  bit failed;

  // Clock with a 10 ns period.
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Fewest lines covering the stored points, filled over subsets from full down.
  function automatic logic [3:0] solve_cover(int n);
    int i;
    int j;
    int k;
    int m;
    int cnt;
    int bestv;
    int cand;
    int full;
    logic [15:0] lm;
    bit same_spot;
    if (n == 0) return 4'd0;
    full = (1 << n) - 1;
    for (i = 0; i < n; i++) begin
      for (j = i + 1; j < n; j++) begin
        lm = 16'(1 << i) | 16'(1 << j);
        same_spot = (pt_x[i] == pt_x[j]) && (pt_y[i] == pt_y[j]);
        for (k = 0; k < n; k++) begin
          if (same_spot) begin
            if (pt_x[k] == pt_x[i] && pt_y[k] == pt_y[i]) lm |= 16'(1 << k);
          end else if ((pt_y[i] - pt_y[j]) * (pt_x[j] - pt_x[k]) ==
                       (pt_x[i] - pt_x[j]) * (pt_y[j] - pt_y[k])) begin
            lm |= 16'(1 << k);
          end
        end
        pair_mask[i][j] = lm;
      end
    end
    for (m = full; m >= 0; m--) begin
      cnt = $countones(m[15:0]);
      bestv = LineCap;
      if (m == full) begin
        fewest_left[m] = 4'd0;
      end else if (cnt + 1 == n || cnt + 2 == n) begin
        fewest_left[m] = 4'd1;
      end else begin
        // Pair the first uncovered point with each later uncovered one.
        for (i = 0; i < n; i++) begin
          if (m[i]) continue;
          for (j = i + 1; j < n; j++) begin
            if (m[j]) continue;
            cand = 1 + fewest_left[(m | int'(pair_mask[i][j])) & full];
            if (cand < bestv) bestv = cand;
          end
          break;
        end
        fewest_left[m] = 4'(bestv);
      end
    end
    return fewest_left[0];
  endfunction

  // Send one point beat and update the predictor when it is accepted.
  task automatic send_point(int x, int y, bit last);
    @(negedge clk);
    while (int'($urandom_range(99)) < send_idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    start = 1'b1;
    in_x_coord = CoordW'(x);
    in_y_coord = CoordW'(y);
    in_last_point = last;
    do @(posedge clk); while (busy);
    points_sent++;
    if (stored_pts < NumSlots) begin
      pt_x[stored_pts] = longint'(in_x_coord);
      pt_y[stored_pts] = longint'(in_y_coord);
      stored_pts++;
    end
    if (last) begin
      expected_lines = {expected_lines, res_t'(solve_cover(stored_pts))};
      stored_pts = 0;
    end
  endtask

  // Compare each result beat with the oldest expected line count.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_lines.size() == 0) begin
        failed = 1'b1;
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: min_lines=%0d", out_min_lines);
      end else if (expected_lines[0] !== out_min_lines) begin
        failed = 1'b1;
        mismatches++;
        if (mismatches <= 10)
          $display("min_lines mismatch: expected %0d, actual %0d",
                   expected_lines[0], out_min_lines);
        void'(expected_lines.pop_front());
      end else begin
        void'(expected_lines.pop_front());
      end
    end
  end

  // One and two points, and three points on or off one line.
  task automatic test_small_sets();
    send_point(1000, -1000, 1'b1);
    send_point(-1000, 1000, 1'b0);
    send_point(0, 0, 1'b1);
    send_point(-1000, -1000, 1'b0);
    send_point(0, 0, 1'b0);
    send_point(1000, 1000, 1'b1);
    send_point(-1, 0, 1'b0);
    send_point(0, -1, 1'b0);
    send_point(3, 7, 1'b1);
  endtask

  // Equal points do not define a line of their own.
  task automatic test_coincident();
    repeat (3) send_point(-7, 12, 1'b0);
    send_point(-7, 12, 1'b1);
    send_point(5, 5, 1'b0);
    send_point(5, 5, 1'b0);
    send_point(1, 2, 1'b0);
    send_point(9, 3, 1'b0);
    send_point(-4, 11, 1'b1);
  endtask

  // Sixteen points on a parabola need the full cap; a seventeenth is dropped.
  task automatic test_cap_and_overflow();
    int i;
    for (i = -8; i < 8; i++) send_point(i, i * i, 1'b0);
    send_point(0, 1000, 1'b1);
  endtask

  // Random sets, mostly small, on coarse grids so lines are shared often.
  task automatic test_random_sets(int idle_pct, int num_points);
    int target;
    int size;
    int p;
    int bx;
    int by;
    int stride;
    int x;
    int y;
    bit on_grid;
    send_idle_pct = idle_pct;
    target = points_sent + num_points;
    while (points_sent < target) begin
      size = ($urandom_range(99) < 90) ? int'($urandom_range(1, 6))
                                       : int'($urandom_range(7, 10));
      on_grid = ($urandom_range(99) < 75);
      bx = $urandom_range(1800) - 900;
      by = $urandom_range(1800) - 900;
      stride = $urandom_range(1, 30);
      for (p = 0; p < size; p++) begin
        if (p > 0 && $urandom_range(99) < 10) begin
          x = int'(pt_x[stored_pts - 1]);
          y = int'(pt_y[stored_pts - 1]);
        end else if (on_grid) begin
          x = bx + stride * (int'($urandom_range(6)) - 3);
          y = by + stride * (int'($urandom_range(6)) - 3);
        end else if ($urandom_range(99) < 10) begin
          x = $urandom_range(1) ? 1000 : -1000;
          y = $urandom_range(1) ? 1000 : -1000;
        end else begin
          x = $urandom_range(2000) - 1000;
          y = $urandom_range(2000) - 1000;
        end
        send_point(x, y, p == size - 1);
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_x_coord = '0;
    in_y_coord = '0;
    in_last_point = 1'b0;
    stored_pts = 0;
    points_sent = 0;
    mismatches = 0;
    failed = 1'b0;
    send_idle_pct = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_small_sets();
    test_coincident();
    test_cap_and_overflow();
    test_random_sets(13, 260);
    test_random_sets(88, 260);
    test_random_sets(0, 260);

    @(negedge clk);
    start = 1'b0;
    while (expected_lines.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (!failed) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run.
  initial begin
    #300_000_000;
    $display("Regression FAIL");
    $finish;
  end
endmodule
